[hdl/fffjp_pkg.sv]
`timescale 1ns / 1ps

package fffjp_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int RESULT_LIMIT    = 16;
  localparam int LIMIT_W         = $clog2(RESULT_LIMIT + 1);

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int JOB_W    = 16;
  localparam int KIND_W   = 2;
  localparam int NCFG_W   = 5;

  localparam logic [NCFG_W-1:0] NODES_RESET = NCFG_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_FREE = 2'd0,
    CMD_ENQUEUE  = 2'd1,
    CMD_PASS     = 2'd2
  } cmd_code_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLACED  = 2'd0,
    KIND_NONE    = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_t;

  typedef struct packed {
    logic node_wr;
    logic q_push;
    logic drop_load;
    logic pass_start;
    logic node_rd_en;
    logic place;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic limit_hit;
    logic searched_zero;
    logic hit;
    logic search_end;
    logic place_ok;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/fffjp_ifs.sv]
`timescale 1ns / 1ps

interface fffjp_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [fffjp_pkg::CMD_W-1:0]      command;
  logic [fffjp_pkg::NODE_W-1:0]     node_index;
  logic [fffjp_pkg::COUNT_W-1:0]    free_count;
  logic [fffjp_pkg::JOB_W-1:0]      job_id;
  logic [fffjp_pkg::COUNT_W-1:0]    job_need;

  modport source (output valid, command, node_index, free_count, job_id, job_need,
                  input ready);
  modport sink   (input valid, command, node_index, free_count, job_id, job_need,
                  output ready);
endinterface

interface fffjp_res_if;
  logic                             valid;
  logic                             ready;
  logic [fffjp_pkg::KIND_W-1:0]     kind;
  logic [fffjp_pkg::NODE_W-1:0]     placed_node;
  logic [fffjp_pkg::JOB_W-1:0]      placed_job;
  logic                             last;

  modport source (output valid, kind, placed_node, placed_job, last, input ready);
  modport sink   (input valid, kind, placed_node, placed_job, last, output ready);
endinterface

interface fffjp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fffjp_pkg::NCFG_W-1:0]     nodes_in_use;

  modport source (output valid, nodes_in_use, input ready);
  modport sink   (input valid, nodes_in_use, output ready);
endinterface

[hdl/fcfs_first_fit_job_placer.sv]
`timescale 1ns / 1ps

// First-come first-served job placer with first-fit node search.
// in_if  : command transactions (set node free count, enqueue job, run pass).
// out_if : result transactions (placed, nothing placed, dropped), last marks
//          the final result produced by one command.
// cfg_if : writes nodes_in_use, always ready; write only while idle.
// Set and accepted enqueue produce no result. An enqueue into a full queue
// produces one dropped result. In a pass the node table is scanned one
// node per cycle through its registered read port, and each placement
// costs a queue-head reload. A pass emits up to 16 placements, or
// one "nothing placed" result. Commands are taken one at a time; the next is
// accepted once the previous one's final result sits in the output register.
// If the receiver stalls, a pass waits with its next result held internally.
// Reset (rst_n, synchronous) empties the queue, zeroes all node free counts
// and sets nodes_in_use to 16.

module fcfs_first_fit_job_placer #(
  parameter int MAX_NODES   = fffjp_pkg::MAX_NODES_DEF,
  parameter int QUEUE_DEPTH = fffjp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  fffjp_cmd_if.sink    in_if,
  fffjp_res_if.source  out_if,
  fffjp_cfg_if.sink    cfg_if
);
  import fffjp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fffjp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_command (in_if.command),
    .stat       (stat),
    .cmd        (cmd)
  );

  fffjp_dp #(
    .MAX_NODES   (MAX_NODES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_node_index (in_if.node_index),
    .in_free_count (in_if.free_count),
    .in_job_id     (in_if.job_id),
    .in_job_need   (in_if.job_need),
    .cmd           (cmd),
    .stat          (stat),
    .out_if        (out_if),
    .cfg_if        (cfg_if)
  );

endmodule

[hdl/fffjp_ctrl.sv]
`timescale 1ns / 1ps

module fffjp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fffjp_pkg::CMD_W-1:0]  in_command,
  input  fffjp_pkg::dp_stat_t          stat,
  output fffjp_pkg::dp_cmd_t           cmd
);
  import fffjp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_PLACE  = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_code_t'(in_command))
            CMD_SET_FREE: cmd.node_wr = 1'b1;
            CMD_ENQUEUE: begin
              if (stat.q_full) begin
                cmd.drop_load = 1'b1;
                state_nxt     = S_FIN;
              end else begin
                cmd.q_push = 1'b1;
              end
            end
            CMD_PASS: begin
              cmd.pass_start = 1'b1;
              state_nxt      = S_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        if (stat.q_empty || stat.limit_hit || stat.searched_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.node_rd_en = 1'b1;
          state_nxt      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.hit) begin
          state_nxt = S_PLACE;
        end else if (stat.search_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.node_rd_en = 1'b1;
        end
      end
      S_PLACE: begin
        if (stat.place_ok) begin
          cmd.place = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/fffjp_dp.sv]
`timescale 1ns / 1ps

module fffjp_dp #(
  parameter int MAX_NODES   = fffjp_pkg::MAX_NODES_DEF,
  parameter int QUEUE_DEPTH = fffjp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fffjp_pkg::NODE_W-1:0]   in_node_index,
  input  logic [fffjp_pkg::COUNT_W-1:0]  in_free_count,
  input  logic [fffjp_pkg::JOB_W-1:0]    in_job_id,
  input  logic [fffjp_pkg::COUNT_W-1:0]  in_job_need,
  input  fffjp_pkg::dp_cmd_t             cmd,
  output fffjp_pkg::dp_stat_t            stat,
  fffjp_res_if.source                    out_if,
  fffjp_cfg_if.sink                      cfg_if
);
  import fffjp_pkg::*;

  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW   = (NW + 1 > NCFG_W) ? NW + 1 : NCFG_W;
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QEW  = JOB_W + COUNT_W;

  // node table
  logic [COUNT_W-1:0] node_mem [MAX_NODES];
  logic [MAX_NODES-1:0] node_vld_r;
  logic [COUNT_W-1:0] node_rd_r;
  logic               node_rd_vld_r;
  logic [NW:0]        n_r;
  logic [NW:0]        nd_r;
  logic [COUNT_W-1:0] node_val;
  logic               node_we;
  logic [NW-1:0]      node_waddr;
  logic [COUNT_W-1:0] node_wdata;
  logic               set_in_range;

  // job queue
  logic [QEW-1:0]     q_mem [QUEUE_DEPTH];
  logic [QEW-1:0]     q_rd_r;
  logic [QW-1:0]      head_r;
  logic [QW-1:0]      tail_r;
  logic [QCW-1:0]     count_r;
  logic [JOB_W-1:0]   head_id;
  logic [COUNT_W-1:0] head_need;

  // pass bookkeeping
  logic [NCFG_W-1:0]  nodes_cfg_r;
  logic [CW-1:0]      searched;
  logic [LIMIT_W-1:0] placed_r;
  kind_t              pend_kind_r;
  logic [NODE_W-1:0]  pend_node_r;
  logic [JOB_W-1:0]   pend_id_r;

  // result register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [NODE_W-1:0]  out_node_r;
  logic [JOB_W-1:0]   out_job_r;
  logic               out_last_r;
  logic               out_free;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_cfg_r <= NODES_RESET;
    end else if (cfg_if.valid) begin
      nodes_cfg_r <= cfg_if.nodes_in_use;
    end
  end

  assign searched = (CW'(nodes_cfg_r) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nodes_cfg_r);

  assign set_in_range = (32'(in_node_index) < 32'(MAX_NODES));
  assign node_val     = node_rd_vld_r ? node_rd_r : '0;
  assign head_id      = q_rd_r[QEW-1:COUNT_W];
  assign head_need    = q_rd_r[COUNT_W-1:0];

  always_comb begin
    node_we    = 1'b0;
    node_waddr = nd_r[NW-1:0];
    node_wdata = node_val - head_need;
    if (cmd.node_wr) begin
      node_we    = set_in_range;
      node_waddr = NW'(in_node_index);
      node_wdata = in_free_count;
    end else if (cmd.place) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (cmd.node_rd_en) begin
      node_rd_r <= node_mem[n_r[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r    <= '0;
      node_rd_vld_r <= 1'b0;
    end else begin
      if (node_we) begin
        node_vld_r[node_waddr] <= 1'b1;
      end
      if (cmd.node_rd_en) begin
        node_rd_vld_r <= node_vld_r[n_r[NW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= '0;
      nd_r <= '0;
    end else if (cmd.pass_start || cmd.place) begin
      n_r <= '0;
    end else if (cmd.node_rd_en) begin
      n_r  <= n_r + 1'b1;
      nd_r <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      q_mem[tail_r] <= {in_job_id, in_job_need};
    end
    q_rd_r <= q_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.q_push) begin
      tail_r  <= (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_r <= count_r + 1'b1;
    end else if (cmd.place) begin
      head_r  <= (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placed_r    <= '0;
      pend_kind_r <= KIND_NONE;
    end else if (cmd.pass_start) begin
      placed_r    <= '0;
      pend_kind_r <= KIND_NONE;
    end else if (cmd.drop_load) begin
      pend_kind_r <= KIND_DROPPED;
    end else if (cmd.place) begin
      placed_r    <= placed_r + 1'b1;
      pend_kind_r <= KIND_PLACED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      pend_node_r <= '0;
      pend_id_r   <= '0;
    end else if (cmd.drop_load) begin
      pend_node_r <= '0;
      pend_id_r   <= in_job_id;
    end else if (cmd.place) begin
      pend_node_r <= NODE_W'(nd_r);
      pend_id_r   <= head_id;
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin || (cmd.place && pend_kind_r == KIND_PLACED)) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin || (cmd.place && pend_kind_r == KIND_PLACED)) begin
      out_kind_r <= pend_kind_r;
      out_node_r <= pend_node_r;
      out_job_r  <= pend_id_r;
      out_last_r <= cmd.fin;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.placed_node = out_node_r;
  assign out_if.placed_job  = out_job_r;
  assign out_if.last        = out_last_r;

  assign stat.q_full        = (count_r == QCW'(QUEUE_DEPTH));
  assign stat.q_empty       = (count_r == '0);
  assign stat.limit_hit     = (placed_r == LIMIT_W'(RESULT_LIMIT));
  assign stat.searched_zero = (searched == '0);
  assign stat.hit           = (node_val >= head_need);
  assign stat.search_end    = ((CW+1)'(nd_r) + 1'b1) >= (CW+1)'(searched);
  assign stat.place_ok      = (pend_kind_r != KIND_PLACED) || out_free;
  assign stat.out_free      = out_free;

endmodule

[sim/fcfs_first_fit_job_placer_tb.sv]
`timescale 1ns / 1ps

module fcfs_first_fit_job_placer_tb;
  import fffjp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PROBE_COUNT   = 22;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [NODE_W-1:0]  node;
    logic [COUNT_W-1:0] free;
    logic [JOB_W-1:0]   job;
    logic [COUNT_W-1:0] need;
  } job_cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] node;
    logic [JOB_W-1:0]  job;
    logic              last;
  } placement_t;

  typedef struct packed {
    logic [JOB_W-1:0]   job;
    logic [COUNT_W-1:0] need;
  } waiting_job_t;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_RESULT,
    ONE_RESULT
  } row_check_t;

  typedef struct packed {
    job_cmd_t   stim;
    row_check_t check;
    placement_t want;
  } probe_row_t;

  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_NONE,   4'h0, 16'h0000, 1'b1}},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'hFFFF, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_PLACED, 4'h0, 16'hFFFF, 1'b1}},
    '{'{CMD_SET_FREE, 4'hF, 16'hFFFF, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'h1234, 16'hFFFF}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_PLACED, 4'hF, 16'h1234, 1'b1}},
    '{'{CMD_SET_FREE, 4'h0, 16'hFFFF, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_UNUSED,   4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'h0001, 16'h8000}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'h0002, 16'h8000}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'h0003, 16'h7FFF}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_PLACED, 4'h0, 16'h0001, 1'b1}},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_NONE,   4'h0, 16'h0000, 1'b1}},
    '{'{CMD_SET_FREE, 4'h3, 16'h8000, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, BY_MODEL, '0},
    '{'{CMD_SET_FREE, 4'h7, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, ONE_RESULT,
      '{KIND_PLACED, 4'h0, 16'h0000, 1'b1}},
    '{'{CMD_SET_FREE, 4'h0, 16'h5555, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_SET_FREE, 4'h1, 16'hAAAA, 16'h0000, 16'h0000}, NO_RESULT, '0},
    '{'{CMD_ENQUEUE,  4'h0, 16'h0000, 16'hA5A5, 16'hAAAA}, NO_RESULT, '0},
    '{'{CMD_PASS,     4'h0, 16'h0000, 16'h0000, 16'h0000}, BY_MODEL, '0}
  };

  logic clk;
  logic rst_n;

  fffjp_cmd_if in_if();
  fffjp_res_if out_if();
  fffjp_cfg_if cfg_if();

  fcfs_first_fit_job_placer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  logic [COUNT_W-1:0] free_left [MAX_NODES_DEF];
  waiting_job_t       backlog [$];
  logic [NCFG_W-1:0]  nodes_cfg;
  placement_t         fresh_results [$];
  placement_t         due_results [$];
  placement_t         want_res;
  int                 errors;
  int                 cmds_taken;
  int                 send_idle;
  int                 recv_stall;
  int                 quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void place_jobs(job_cmd_t c);
    int searched;
    int placed;
    int hit;
    bit blocked;
    fresh_results.delete();
    case (c.command)
      CMD_SET_FREE: free_left[c.node] = c.free;
      CMD_ENQUEUE: begin
        if (backlog.size() >= QUEUE_DEPTH_DEF)
          fresh_results.insert(fresh_results.size(),
                               placement_t'{KIND_DROPPED, 4'h0, c.job, 1'b1});
        else
          backlog.insert(backlog.size(), waiting_job_t'{c.job, c.need});
      end
      CMD_PASS: begin
        searched = (nodes_cfg > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(nodes_cfg);
        placed = 0;
        blocked = 1'b0;
        while (backlog.size() > 0 && placed < RESULT_LIMIT && !blocked) begin
          hit = -1;
          for (int n = 0; n < searched; n++)
            if (hit < 0 && free_left[n] >= backlog[0].need) hit = n;
          if (hit < 0) begin
            blocked = 1'b1;
          end else begin
            free_left[hit] = free_left[hit] - backlog[0].need;
            fresh_results.insert(fresh_results.size(),
                                 placement_t'{KIND_PLACED, NODE_W'(hit), backlog[0].job, 1'b0});
            void'(backlog.pop_front());
            placed++;
          end
        end
        if (placed == 0)
          fresh_results.insert(fresh_results.size(),
                               placement_t'{KIND_NONE, 4'h0, 16'h0000, 1'b1});
        else
          fresh_results[fresh_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(job_cmd_t c, row_check_t chk, placement_t want);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= c.command;
    in_if.node_index <= c.node;
    in_if.free_count <= c.free;
    in_if.job_id     <= c.job;
    in_if.job_need   <= c.need;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (c.command != CMD_UNUSED) cmds_taken++;
    place_jobs(c);
    case (chk)
      BY_MODEL:
        foreach (fresh_results[i]) due_results.insert(due_results.size(), fresh_results[i]);
      ONE_RESULT: due_results.insert(due_results.size(), want);
      default: ;
    endcase
  endtask

  task automatic issue(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                       logic [COUNT_W-1:0] free, logic [COUNT_W-1:0] need);
    send_command('{cmd, node, free, JOB_W'($urandom), need}, BY_MODEL, '0);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_nodes(logic [NCFG_W-1:0] v);
    cfg_if.valid        <= 1'b1;
    cfg_if.nodes_in_use <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    nodes_cfg = v;
  endtask

  function automatic logic [COUNT_W-1:0] pick_free();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'hFFFF;
    if (r < 20) return 16'h0000;
    if (r < 60) return COUNT_W'($urandom_range(0, 3000));
    return COUNT_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_need();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 80) return COUNT_W'($urandom_range(0, 800));
    if (r < 90) return COUNT_W'($urandom);
    return 16'hFFFF;
  endfunction

  task automatic run_phase(int items, int idle_pct, int stall_pct);
    int first;
    int span;
    first = cmds_taken;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    while (cmds_taken - first < items) begin
      span = (nodes_cfg == 0) ? 1 : ((nodes_cfg > MAX_NODES_DEF) ? MAX_NODES_DEF : nodes_cfg);
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0: issue(CMD_UNUSED, NODE_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
          1: issue(CMD_PASS, NODE_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
          default: issue(CMD_SET_FREE, NODE_W'($urandom), pick_free(), COUNT_W'($urandom));
        endcase
      end else begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(99) < 80)
            issue(CMD_SET_FREE, NODE_W'($urandom_range(0, span - 1)), pick_free(),
                  COUNT_W'($urandom));
          else
            issue(CMD_SET_FREE, NODE_W'($urandom), pick_free(), COUNT_W'($urandom));
        end
        repeat ($urandom_range(1, 18))
          issue(CMD_ENQUEUE, NODE_W'($urandom), COUNT_W'($urandom), pick_need());
        issue(CMD_PASS, NODE_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
      end
      if ($urandom_range(99) < 3) drain_results();
    end
  endtask

  always @(posedge clk) out_if.ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d node %0d job %h last %b", $time,
                 out_if.kind, out_if.placed_node, out_if.placed_job, out_if.last);
        errors++;
      end else begin
        want_res = due_results.pop_front();
        if (out_if.kind !== want_res.kind || out_if.placed_node !== want_res.node ||
            out_if.placed_job !== want_res.job || out_if.last !== want_res.last) begin
          $display("%0t: expected %0d/%0d/%h/%b, actual %0d/%0d/%h/%b (kind/node/job/last)",
                   $time, want_res.kind, want_res.node, want_res.job, want_res.last,
                   out_if.kind, out_if.placed_node, out_if.placed_job, out_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fcfs_first_fit_job_placer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_SET_FREE;
    in_if.node_index    = '0;
    in_if.free_count    = '0;
    in_if.job_id        = '0;
    in_if.job_need      = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.nodes_in_use = NODES_RESET;
    out_if.ready        = 1'b0;
    errors              = 0;
    cmds_taken          = 0;
    send_idle           = 0;
    recv_stall          = 0;
    quiet_cycles        = 0;
    nodes_cfg           = NODES_RESET;
    foreach (free_left[i]) free_left[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBE_ROWS[i])
      send_command(PROBE_ROWS[i].stim, PROBE_ROWS[i].check, PROBE_ROWS[i].want);
    drain_results();

    write_nodes(NCFG_W'(16));
    run_phase(60, 0, 0);
    drain_results();
    write_nodes(NCFG_W'(1));
    run_phase(60, 59, 0);
    drain_results();
    write_nodes(NCFG_W'(31));
    run_phase(60, 0, 59);
    drain_results();
    write_nodes(NCFG_W'(0));
    run_phase(30, 28, 28);
    drain_results();
    write_nodes(NCFG_W'($urandom_range(2, 15)));
    run_phase(60, 28, 28);
    drain_results();
    write_nodes(NCFG_W'(17));
    run_phase(30, 0, 0);
    // sender holds off until the block has delivered everything
    drain_results();
    run_phase(30, 59, 59);
    drain_results();

    if (errors == 0 && due_results.size() == 0)
      $display("fcfs_first_fit_job_placer: match");
    else
      $display("fcfs_first_fit_job_placer: mismatch");
    $finish;
  end

endmodule
